@@ rtl/tsg_pkg.sv @@
package tsg_pkg;

	localparam int unsigned XW     = 10;
	localparam int unsigned YW     = 9;
	localparam int unsigned HWW    = 8;
	localparam int unsigned LENW   = 9;
	localparam int unsigned STACKW = 5;
	localparam int unsigned CALCW  = 12;
	localparam int unsigned ADDRW  = 3;
	localparam int unsigned DATAW  = 32;

	localparam logic [HWW-1:0]    HW_RESET    = 8'd40;
	localparam logic [LENW-1:0]   LEN_RESET   = 9'd150;
	localparam logic [STACKW-1:0] STACK_RESET = 5'd1;
	localparam int                STACK_MAX   = 25;

	// scroll thresholds, compared directly against the raw y offset with no scaling
	localparam int SCROLL_FAST = 50;
	localparam int SCROLL_SLOW = 30;

	typedef enum logic [0:0] {
		REG_HALF_WIDTH = 1'b0,
		REG_STROKE_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		DIR_NONE  = 3'd0,
		DIR_UP    = 3'd1,
		DIR_DOWN  = 3'd2,
		DIR_LEFT  = 3'd3,
		DIR_RIGHT = 3'd4
	} dir_t;

	typedef enum logic [2:0] {
		MODE_UP    = 3'd1,
		MODE_DOWN  = 3'd2,
		MODE_LEFT  = 3'd3,
		MODE_RIGHT = 3'd4,
		MODE_IDLE  = 3'd5,
		MODE_WAIT  = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_PAN   = 2'd1,
		CMD_UNDO  = 2'd2,
		CMD_STACK = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [HWW-1:0]  half_width;
		logic [LENW-1:0] stroke_len;
	} cfg_t;

endpackage

@@ rtl/tsg_in_if.sv @@
interface tsg_in_if;
	logic                    valid;
	logic                    ready;
	logic                    point_present;
	logic [tsg_pkg::XW-1:0]  pos_x;
	logic [tsg_pkg::YW-1:0]  pos_y;

	modport source(output valid, point_present, pos_x, pos_y, input ready);
	modport sink(input valid, point_present, pos_x, pos_y, output ready);
endinterface

@@ rtl/tsg_out_if.sv @@
interface tsg_out_if;
	logic                        valid;
	logic                        ready;
	logic                        is_active;
	logic [2:0]                  leg_one;
	logic [2:0]                  leg_two;
	logic [1:0]                  command;
	logic [tsg_pkg::XW-1:0]      pan_x_out;
	logic [tsg_pkg::YW-1:0]      pan_y_out;
	logic [tsg_pkg::STACKW-1:0]  stack_level;

	modport source(output valid, is_active, leg_one, leg_two, command, pan_x_out, pan_y_out,
		stack_level, input ready);
	modport sink(input valid, is_active, leg_one, leg_two, command, pan_x_out, pan_y_out,
		stack_level, output ready);
endinterface

@@ rtl/tsg_cfg.sv @@
module tsg_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsg_pkg::ADDRW-1:0]   paddr,
	input  logic [tsg_pkg::DATAW-1:0]   pwdata,
	output logic [tsg_pkg::DATAW-1:0]   prdata,
	output logic                        pready,
	output tsg_pkg::cfg_t               cfg
);

	tsg_pkg::cfg_t     cfg_q;
	tsg_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = tsg_pkg::reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width <= tsg_pkg::HW_RESET;
			cfg_q.stroke_len <= tsg_pkg::LEN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				tsg_pkg::REG_HALF_WIDTH: cfg_q.half_width <= pwdata[tsg_pkg::HWW-1:0];
				tsg_pkg::REG_STROKE_LEN: cfg_q.stroke_len <= pwdata[tsg_pkg::LENW-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			tsg_pkg::REG_HALF_WIDTH: prdata[tsg_pkg::HWW-1:0]  = cfg_q.half_width;
			tsg_pkg::REG_STROKE_LEN: prdata[tsg_pkg::LENW-1:0] = cfg_q.stroke_len;
		endcase
	end

endmodule

@@ rtl/tsg_core.sv @@
module tsg_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsg_pkg::cfg_t                cfg,
	input  logic                         adv,
	input  logic                         present_s1,
	input  logic [tsg_pkg::XW-1:0]       x_s1,
	input  logic [tsg_pkg::YW-1:0]       y_s1,
	output logic                         is_active_s2,
	output tsg_pkg::dir_t                leg_one_s2,
	output tsg_pkg::dir_t                leg_two_s2,
	output tsg_pkg::cmd_t                command_s2,
	output logic [tsg_pkg::XW-1:0]       pan_x_s2,
	output logic [tsg_pkg::YW-1:0]       pan_y_s2,
	output logic [tsg_pkg::STACKW-1:0]   stack_s2
);

	localparam int CW = tsg_pkg::CALCW;

	tsg_pkg::mode_t               mode_q, mode_d;
	logic [tsg_pkg::XW-1:0]       anchor_x_q, anchor_x_d;
	logic [tsg_pkg::YW-1:0]       anchor_y_q, anchor_y_d;
	tsg_pkg::dir_t                first_q, first_d, second_q, second_d;
	logic                         active_q, active_d;
	logic [tsg_pkg::STACKW-1:0]   stack_q, stack_d;
	logic [tsg_pkg::XW-1:0]       pan_x_q, pan_x_d;
	logic [tsg_pkg::YW-1:0]       pan_y_q, pan_y_d;
	tsg_pkg::cmd_t                cmd_d;

	logic signed [CW-1:0] sx, sy, ax, ay, hw, len, reach, ay_eff, diff;
	logic signed [6:0]    speed, stack_sum;
	logic                 side_x, side_y, fin;
	tsg_pkg::dir_t        fin_dir;

	assign sx    = $signed({{(CW-tsg_pkg::XW){1'b0}}, x_s1});
	assign sy    = $signed({{(CW-tsg_pkg::YW){1'b0}}, y_s1});
	assign ax    = $signed({{(CW-tsg_pkg::XW){1'b0}}, anchor_x_q});
	assign ay    = $signed({{(CW-tsg_pkg::YW){1'b0}}, anchor_y_q});
	assign hw    = $signed({{(CW-tsg_pkg::HWW){1'b0}}, cfg.half_width});
	assign len   = $signed({{(CW-tsg_pkg::LENW){1'b0}}, cfg.stroke_len});
	assign reach = len - hw;

	assign side_x = (sx <= ax + hw) && (sx >= ax - hw);
	assign side_y = (sy <= ay + hw) && (sy >= ay - hw);

	always_comb begin
		mode_d     = mode_q;
		anchor_x_d = anchor_x_q;
		anchor_y_d = anchor_y_q;
		first_d    = first_q;
		second_d   = second_q;
		active_d   = active_q;
		stack_d    = stack_q;
		pan_x_d    = pan_x_q;
		pan_y_d    = pan_y_q;
		cmd_d      = tsg_pkg::CMD_NONE;
		fin        = 1'b0;
		fin_dir    = tsg_pkg::DIR_NONE;
		ay_eff     = ay;
		diff       = '0;
		speed      = '0;
		stack_sum  = '0;

		if (!present_s1) begin
			active_d = 1'b0;
			first_d  = tsg_pkg::DIR_NONE;
			second_d = tsg_pkg::DIR_NONE;
			mode_d   = tsg_pkg::MODE_IDLE;
		end else if (!active_q) begin
			unique case (mode_q)
				tsg_pkg::MODE_IDLE: begin
					anchor_x_d = x_s1;
					anchor_y_d = y_s1;
					mode_d     = tsg_pkg::MODE_WAIT;
				end
				tsg_pkg::MODE_WAIT: begin
					priority if (sx < ax - hw) begin
						mode_d = tsg_pkg::MODE_LEFT;
					end else if (sx > ax + hw) begin
						mode_d = tsg_pkg::MODE_RIGHT;
					end else if (sy > ay + hw) begin
						mode_d = tsg_pkg::MODE_DOWN;
					end else if (sy < ay - hw) begin
						mode_d = tsg_pkg::MODE_UP;
					end else begin
						mode_d = tsg_pkg::MODE_WAIT;
					end
					if (mode_d != tsg_pkg::MODE_WAIT) begin
						anchor_x_d = x_s1;
						anchor_y_d = y_s1;
					end
				end
				tsg_pkg::MODE_UP: begin
					if (!(side_x && sy >= ay - len)) mode_d = tsg_pkg::MODE_IDLE;
					else if (sy <= ay - reach) begin
						fin     = 1'b1;
						fin_dir = tsg_pkg::DIR_UP;
					end
				end
				tsg_pkg::MODE_DOWN: begin
					if (!(side_x && sy <= ay + len)) mode_d = tsg_pkg::MODE_IDLE;
					else if (sy >= ay + reach) begin
						fin     = 1'b1;
						fin_dir = tsg_pkg::DIR_DOWN;
					end
				end
				tsg_pkg::MODE_LEFT: begin
					if (!(side_y && sx >= ax - len)) mode_d = tsg_pkg::MODE_IDLE;
					else if (sx <= ax - reach) begin
						fin     = 1'b1;
						fin_dir = tsg_pkg::DIR_LEFT;
					end
				end
				tsg_pkg::MODE_RIGHT: begin
					if (!(side_y && sx <= ax + len)) mode_d = tsg_pkg::MODE_IDLE;
					else if (sx >= ax + reach) begin
						fin     = 1'b1;
						fin_dir = tsg_pkg::DIR_RIGHT;
					end
				end
				default: mode_d = tsg_pkg::MODE_IDLE;
			endcase
			if (fin) begin
				if (first_q == tsg_pkg::DIR_NONE) begin
					first_d = fin_dir;
					mode_d  = tsg_pkg::MODE_IDLE;
				end else begin
					second_d = fin_dir;
					active_d = 1'b1;
				end
			end
		end else begin
			priority if (first_q == tsg_pkg::DIR_UP && second_q == tsg_pkg::DIR_RIGHT) begin
				pan_x_d = x_s1;
				pan_y_d = y_s1;
				cmd_d   = tsg_pkg::CMD_PAN;
			end else if (first_q == tsg_pkg::DIR_DOWN && second_q == tsg_pkg::DIR_LEFT) begin
				cmd_d = tsg_pkg::CMD_UNDO;
			end else if (first_q == tsg_pkg::DIR_LEFT && second_q == tsg_pkg::DIR_DOWN) begin
				if (mode_q != tsg_pkg::MODE_IDLE) begin
					anchor_y_d = y_s1;
					ay_eff     = sy;
					mode_d     = tsg_pkg::MODE_IDLE;
				end
				diff = sy - ay_eff;
				priority if (diff <= -CW'(tsg_pkg::SCROLL_FAST)) speed = -7'sd4;
				else if (diff <= -CW'(tsg_pkg::SCROLL_SLOW)) speed = -7'sd1;
				else if (diff >= CW'(tsg_pkg::SCROLL_FAST)) speed = 7'sd4;
				else if (diff >= CW'(tsg_pkg::SCROLL_SLOW)) speed = 7'sd1;
				else speed = 7'sd0;
				stack_sum = $signed({2'b00, stack_q}) + speed;
				priority if (stack_sum >= 7'(tsg_pkg::STACK_MAX))
					stack_d = tsg_pkg::STACKW'(tsg_pkg::STACK_MAX);
				else if (stack_sum <= 7'sd0) stack_d = '0;
				else stack_d = stack_sum[tsg_pkg::STACKW-1:0];
				cmd_d = tsg_pkg::CMD_STACK;
			end else begin
				cmd_d = tsg_pkg::CMD_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= tsg_pkg::MODE_IDLE;
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			first_q    <= tsg_pkg::DIR_NONE;
			second_q   <= tsg_pkg::DIR_NONE;
			active_q   <= 1'b0;
			stack_q    <= tsg_pkg::STACK_RESET;
			pan_x_q    <= '0;
			pan_y_q    <= '0;
		end else if (adv) begin
			mode_q     <= mode_d;
			anchor_x_q <= anchor_x_d;
			anchor_y_q <= anchor_y_d;
			first_q    <= first_d;
			second_q   <= second_d;
			active_q   <= active_d;
			stack_q    <= stack_d;
			pan_x_q    <= pan_x_d;
			pan_y_q    <= pan_y_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			is_active_s2 <= active_d;
			leg_one_s2   <= first_d;
			leg_two_s2   <= second_d;
			command_s2   <= cmd_d;
			pan_x_s2     <= pan_x_d;
			pan_y_s2     <= pan_y_d;
			stack_s2     <= stack_d;
		end
	end

endmodule

@@ rtl/two_stroke_gesture_recognizer.sv @@
// channel     dir  beat contents
// point_in    in   point_present, pos_x, pos_y
// result_out  out  is_active, leg_one, leg_two, command, pan_x_out, pan_y_out, stack_level
// apb         in   corridor_half_width at 0x0, stroke_length at 0x4
//
// one beat per cycle sustained while result_out is not stalled; a result passes through
// the input register, then state update and result register in the same cycle
// arst_n resets control and gesture state (stack level to 1); registers return to 40 and 150
// a stalled result holds, the input register fills, then point_in.ready drops
module two_stroke_gesture_recognizer (
	input  logic                        clk,
	input  logic                        arst_n,
	tsg_in_if.sink                      point_in,
	tsg_out_if.source                   result_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsg_pkg::ADDRW-1:0]   paddr,
	input  logic [tsg_pkg::DATAW-1:0]   pwdata,
	output logic [tsg_pkg::DATAW-1:0]   prdata,
	output logic                        pready
);

	tsg_pkg::cfg_t              cfg;
	logic                       valid_s1, valid_s2, adv;
	logic                       present_s1;
	logic [tsg_pkg::XW-1:0]     x_s1;
	logic [tsg_pkg::YW-1:0]     y_s1;
	tsg_pkg::dir_t              leg_one_s2, leg_two_s2;
	tsg_pkg::cmd_t              command_s2;

	assign adv            = valid_s1 && (!valid_s2 || result_out.ready);
	assign point_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (point_in.valid && point_in.ready) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= 1'b1;
			else if (result_out.ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (point_in.valid && point_in.ready) begin
			present_s1 <= point_in.point_present;
			x_s1       <= point_in.pos_x;
			y_s1       <= point_in.pos_y;
		end
	end

	tsg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tsg_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.adv          (adv),
		.present_s1   (present_s1),
		.x_s1         (x_s1),
		.y_s1         (y_s1),
		.is_active_s2 (result_out.is_active),
		.leg_one_s2   (leg_one_s2),
		.leg_two_s2   (leg_two_s2),
		.command_s2   (command_s2),
		.pan_x_s2     (result_out.pan_x_out),
		.pan_y_s2     (result_out.pan_y_out),
		.stack_s2     (result_out.stack_level)
	);

	assign result_out.valid   = valid_s2;
	assign result_out.leg_one = leg_one_s2;
	assign result_out.leg_two = leg_two_s2;
	assign result_out.command = command_s2;

endmodule
